// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; FPF_ASSERT expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define FPF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion on the default clock and reset names
`define FPF_ASSERT(lbl, prop, msg) \
    `FPF_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- sv/fpf_pkg.sv -----
// shared types and constants of the frame peak finder
// no dependencies; used by every module of the block
package fpf_pkg;

    localparam int FRAME_DEPTH_DEF = 1024;
    localparam int MAX_PEAKS_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int TOL_BITS  = 16;
    localparam int SKIP_BITS = 4;

    localparam logic [TOL_BITS-1:0]  TOL_RESET  = 16'd8;
    localparam logic [SKIP_BITS-1:0] SKIP_RESET = 4'd3;

    localparam logic [4:0] COUNT_MAX = 5'd31;

    typedef logic [0:0]  t_cfg_index;
    typedef logic [15:0] t_cfg_data;

    localparam t_cfg_index REG_TOLERANCE = 1'd0;
    localparam t_cfg_index REG_SKIP      = 1'd1;

    typedef struct packed {
        logic [15:0] sample;
        logic        frame_end;
    } t_in_item;

    typedef struct packed {
        logic [9:0]  peak_index;
        logic        peak_valid;
        logic [15:0] peak_level;
        logic [4:0]  interval_count;
        logic        overflow;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_fin;
        logic emit_rd;
        logic emit_load;
        logic frame_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_issue_last;
        logic out_last;
    } t_dp_sts;

endpackage

// ----- sv/frame_peak_finder_unit.sv -----
// samples load at one per cycle while the block is in its load phase; after the frame-end
// sample, the stored frame is scanned with one sample-store read per cycle
// each result is then fetched from the peak buffer, loaded into the result register and shown
// until taken; the next frame is accepted once the last result of the frame is taken
// reset: synchronous active-low; clears frame state, sets tolerance 8 and skip count 3
module frame_peak_finder_unit #(
    parameter int FRAME_DEPTH = fpf_pkg::FRAME_DEPTH_DEF,
    parameter int MAX_PEAKS   = fpf_pkg::MAX_PEAKS_DEF,
    parameter int SAMPLE_BITS = fpf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fpf_pkg::t_in_item   i_in_data,
    // result request channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fpf_pkg::t_out_item  o_out_data,
    // register write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  fpf_pkg::t_cfg_index i_cfg_index,
    input  fpf_pkg::t_cfg_data  i_cfg_data
);
    import fpf_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // register writes must land only while the block is idle, unenforced; always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: load phase, scan phase, then one result at a time
    fpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_in_data.frame_end),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // storage, window test, peak buffer and the result register
    fpf_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .MAX_PEAKS   (MAX_PEAKS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/fpf_datapath.sv -----
// datapath: sample store, running max, window scan, peak buffer, result register
// depends on fpf_pkg; driven by fpf_ctrl commands
module fpf_datapath #(
    parameter int FRAME_DEPTH = 1024,
    parameter int MAX_PEAKS   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpf_pkg::t_in_item     i_in_data,
    input  logic                  i_cfg_we,
    input  fpf_pkg::t_cfg_index   i_cfg_index,
    input  fpf_pkg::t_cfg_data    i_cfg_data,
    input  fpf_pkg::t_dp_cmd      i_cmd,
    output fpf_pkg::t_dp_sts      o_sts,
    output fpf_pkg::t_out_item    o_out_data
);
    import fpf_pkg::*;

    localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int KW = $clog2(MAX_PEAKS + 1);
    localparam int PW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int EW = ((SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS) + 1;

    // configuration
    logic [TOL_BITS-1:0]  r_tolerance;
    logic [SKIP_BITS-1:0] r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
            r_skip      <= SKIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_BITS-1:0];
                REG_SKIP:      r_skip      <= i_cfg_data[SKIP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sample store and frame state
    logic [SAMPLE_BITS-1:0] r_store [FRAME_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [CW-1:0]          r_wr_count;
    logic [SAMPLE_BITS-1:0] r_running_max;
    logic                   r_dropped;
    logic [CW-1:0]          r_scan_addr;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic                   w_has_room;

    assign w_sample   = SAMPLE_BITS'(i_in_data.sample);
    assign w_has_room = r_wr_count < CW'(FRAME_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_has_room) begin
            r_store[r_wr_count[AW-1:0]] <= w_sample;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_store[r_scan_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clr) begin
            r_wr_count    <= '0;
            r_running_max <= '0;
            r_dropped     <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_has_room) begin
                if (r_wr_count >= CW'(r_skip) && w_sample > r_running_max) begin
                    r_running_max <= w_sample;
                end
                r_wr_count <= r_wr_count + CW'(1);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // scan: read address, then window test on the registered read data
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          r_prev_hit;
    logic [AW-1:0] r_prev_idx;
    logic          w_hit;
    logic [EW-1:0] w_s_ext;
    logic [EW-1:0] w_m_ext;
    logic [EW-1:0] w_t_ext;

    assign w_s_ext = EW'(r_rd_data);
    assign w_m_ext = EW'(r_running_max);
    assign w_t_ext = EW'(r_tolerance);
    // strict window: max - tol < s < max + tol
    assign w_hit   = (w_s_ext + w_t_ext > w_m_ext) && (w_s_ext < w_m_ext + w_t_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clr) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan_addr <= r_scan_addr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
        r_rd_idx <= r_scan_addr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clr) begin
            r_prev_hit <= 1'b0;
        end else if (r_rd_vld) begin
            r_prev_hit <= w_hit;
        end
        if (r_rd_vld) begin
            r_prev_idx <= r_rd_idx;
        end
    end

    // run end: previous index hit and this one misses, or last index hit
    logic w_keep_en;
    assign w_keep_en = r_prev_hit && ((r_rd_vld && !w_hit) || i_cmd.scan_fin);

    // peak buffer
    logic [AW-1:0] r_peaks [MAX_PEAKS];
    logic [AW-1:0] r_pk_data;
    logic [KW-1:0] r_kept;
    logic          r_excess;
    logic [KW-1:0] r_emit_ptr;
    logic          w_room_pk;

    assign w_room_pk = r_kept < KW'(MAX_PEAKS);

    always_ff @(posedge i_clk) begin
        if (w_keep_en && w_room_pk) begin
            r_peaks[r_kept[PW-1:0]] <= r_prev_idx;
        end
        if (i_cmd.emit_rd) begin
            r_pk_data <= r_peaks[r_emit_ptr[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clr) begin
            r_kept   <= '0;
            r_excess <= 1'b0;
        end else if (w_keep_en) begin
            if (w_room_pk) begin
                r_kept <= r_kept + KW'(1);
            end else begin
                r_excess <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.frame_clr) begin
            r_emit_ptr <= '0;
        end else if (i_cmd.emit_load) begin
            r_emit_ptr <= r_emit_ptr + KW'(1);
        end
    end

    // result register
    logic [7:0] w_kept8;
    logic [4:0] w_count;
    logic       w_emit_last;
    t_out_item  r_out;

    assign w_kept8     = 8'(r_kept);
    assign w_count     = (w_kept8 == 8'd0) ? 5'd0 :
                         (w_kept8 > 8'(COUNT_MAX) + 8'd1) ? COUNT_MAX : 5'(w_kept8 - 8'd1);
    assign w_emit_last = (r_kept == '0) || ((r_emit_ptr + KW'(1)) == r_kept);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out.peak_index     <= (r_kept == '0) ? 10'd0 : 10'(r_pk_data);
            r_out.peak_valid     <= r_kept != '0;
            r_out.peak_level     <= 16'(r_running_max);
            r_out.interval_count <= w_count;
            r_out.overflow       <= r_dropped | r_excess;
            r_out.last           <= w_emit_last;
        end
    end

    assign o_out_data            = r_out;
    assign o_sts.scan_issue_last = (r_scan_addr + CW'(1)) == r_wr_count;
    assign o_sts.out_last        = r_out.last;

endmodule

// ----- sv/fpf_ctrl.sv -----
// controller state machine: load, scan, emit sequencing
// depends on fpf_pkg; drives fpf_datapath commands
module fpf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_frame_end,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fpf_pkg::t_dp_sts i_sts,
    output fpf_pkg::t_dp_cmd o_cmd
);
    import fpf_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_SHOW  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_frame_end) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                o_cmd.scan_fin = 1'b1;
                n_state        = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_PUT;
            end
            S_PUT: begin
                o_cmd.emit_load = 1'b1;
                n_state         = S_SHOW;
            end
            S_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.frame_clr = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ----- sv/fpf_checker.sv -----
// port-level checks of the frame peak finder, bound to the top level
// depends on fpf_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input fpf_pkg::t_in_item   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fpf_pkg::t_out_item  o_out_data,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input fpf_pkg::t_cfg_index i_cfg_index,
    input fpf_pkg::t_cfg_data  i_cfg_data
);
    import fpf_pkg::*;

    // a stalled result holds
    `FPF_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result changed while stalled")

    // no sample is taken while a result of a frame is offered
    `FPF_ASSERT(a_no_load_while_out, o_out_valid |-> !o_in_ready, "sample ready during result phase")

    // an empty frame gives a single final result with zero count
    `FPF_ASSERT(a_empty_result, o_out_valid && !o_out_data.peak_valid |-> o_out_data.last && o_out_data.interval_count == 5'd0, "bad empty-frame result")

    // a sample that does not end the frame gives no result next cycle
    `FPF_ASSERT(a_mid_frame_quiet, i_in_valid && o_in_ready && !i_in_data.frame_end |=> !o_out_valid, "result during frame load")

    // after a non-final result the block stays in its result phase
    `FPF_ASSERT(a_more_results, o_out_valid && i_out_ready && !o_out_data.last |=> !o_in_ready, "frame closed before last result")

endmodule

bind frame_peak_finder_unit fpf_checker u_fpf_checker (.*);
